>>> hdl/stlc_pkg.sv
package stlc_pkg;

	// Input transaction kinds, carried on s_tuser
	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_CMD  = 2'd1,
		OP_CSUM = 2'd2
	} op_t;

	// Reported status, in rising priority
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_CSUM_WARN = 3'd1,
		ST_NO_CMD    = 3'd2,
		ST_WATCHDOG  = 3'd3,
		ST_LOW_BATT  = 3'd4
	} status_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_BATT_MIN = 2'd0,
		CFG_WD_EN    = 2'd1,
		CFG_WD_LIMIT = 2'd2
	} cfg_idx_t;

	// Per-channel flasher state
	typedef struct packed {
		logic       phase;
		logic [3:0] count;
		logic       drive;
	} flash_t;

	localparam int unsigned N_LAMPS = 3;
	localparam int unsigned N_CHANS = 4;   // three lamps and the status LED
	localparam int unsigned CH_LED  = 3;

	localparam logic [7:0]  LEVEL_ON    = 8'd10;
	localparam logic [7:0]  PAUSE_STEPS = 8'd4;

	localparam logic [9:0]  BATT_MIN_RST = 10'd100;
	localparam logic [15:0] WD_LIMIT_RST = 16'd2;
	localparam logic [15:0] WD_COUNT_RST = 16'd3;
	localparam logic [15:0] WD_COUNT_MAX = 16'hFFFF;

endpackage

>>> hdl/signal_tower_lamp_controller.sv
// The result of a transaction is registered and appears on m_tdata in the cycle after it is accepted.
// One transaction per cycle while s_tready is high; the state update is a single registered pass.
// s_tready drops only while a result is held and m_tready is low.
// Reset (arst_n low, asynchronous): watchdog status, red steady on, other lamps off,
// all flashers idle, no command seen, registers at their default values.
module signal_tower_lamp_controller (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// [9:0] battery_sample, [17:10] red_level, [25:18] yellow_level,
	// [33:26] green_level, [39:34] zero
	input  logic [39:0] s_tdata,
	// [1:0] opcode
	input  logic [1:0]  s_tuser,
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] red_lamp, [1] yellow_lamp, [2] green_lamp, [3] status_led,
	// [6:4] status_code, [7] low_battery
	output logic [7:0]  m_tdata
);

	// configuration registers
	logic [9:0]  batt_min_q;
	logic        wd_en_q;
	logic [15:0] wd_limit_q;

	// controller state
	logic                half_q,     half_nx;
	logic [15:0]         wd_cnt_q,   wd_cnt_nx;
	logic                seen_q,     seen_nx;
	logic                csum_q,     csum_nx;
	logic                batt_flag_q, batt_flag_nx;
	stlc_pkg::status_t   status_q,   status_nx;
	logic [7:0]          cmd_q [stlc_pkg::N_LAMPS];
	logic [7:0]          cmd_nx [stlc_pkg::N_LAMPS];
	logic [7:0]          act_q [stlc_pkg::N_LAMPS];
	logic [7:0]          act_nx [stlc_pkg::N_LAMPS];
	stlc_pkg::flash_t    fl_q [stlc_pkg::N_CHANS];
	stlc_pkg::flash_t    fl_nx [stlc_pkg::N_CHANS];

	// output register
	logic        out_valid_q;
	logic [7:0]  out_data_q;
	logic [7:0]  out_data_nx;

	logic        s_acc;
	stlc_pkg::op_t op;
	logic [9:0]  sample;
	logic [7:0]  led_level;

	// One flash step of a channel at the given level
	function automatic stlc_pkg::flash_t flash_step(stlc_pkg::flash_t cur, logic [7:0] level);
		stlc_pkg::flash_t nx;
		logic [3:0]       cnt;
		nx  = cur;
		cnt = cur.count + 4'd1;
		if (level == 8'd0 || level > stlc_pkg::LEVEL_ON) begin
			nx.drive = 1'b0;
		end else if (level == stlc_pkg::LEVEL_ON) begin
			nx.drive = 1'b1;
		end else if (cur.phase) begin
			nx.phase = 1'b0;
			nx.drive = 1'b0;
		end else begin
			nx.count = cnt;
			if ({4'd0, cnt} <= level) begin
				nx.drive = 1'b1;
				nx.phase = 1'b1;
			end else if ({4'd0, cnt} > level + stlc_pkg::PAUSE_STEPS) begin
				nx.count = 4'd0;
			end
		end
		return nx;
	endfunction

	assign s_tready = !out_valid_q || m_tready;
	assign s_acc    = s_tvalid && s_tready;
	assign op       = stlc_pkg::op_t'(s_tuser);
	assign sample   = s_tdata[9:0];
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Hold configuration; writes are to arrive only while idle, which the block itself does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batt_min_q <= stlc_pkg::BATT_MIN_RST;
			wd_en_q    <= 1'b1;
			wd_limit_q <= stlc_pkg::WD_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (stlc_pkg::cfg_idx_t'(cfg_index))
				stlc_pkg::CFG_BATT_MIN: batt_min_q <= cfg_data[9:0];
				stlc_pkg::CFG_WD_EN:    wd_en_q    <= cfg_data[0];
				stlc_pkg::CFG_WD_LIMIT: wd_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next state for the accepted transaction
	always_comb begin
		half_nx      = half_q;
		wd_cnt_nx    = wd_cnt_q;
		seen_nx      = seen_q;
		csum_nx      = csum_q;
		batt_flag_nx = batt_flag_q;
		status_nx    = status_q;
		cmd_nx       = cmd_q;
		act_nx       = act_q;
		fl_nx        = fl_q;
		led_level    = 8'd0;

		case (op)
			stlc_pkg::OP_TICK: begin
				// advance the saturating watchdog, or clear it while the watchdog is disabled
				if (wd_en_q) begin
					if (wd_cnt_q != stlc_pkg::WD_COUNT_MAX)
						wd_cnt_nx = wd_cnt_q + 16'd1;
				end else begin
					wd_cnt_nx = 16'd0;
				end

				// pick status by priority, using the flag from before this tick
				if (batt_flag_q) begin
					status_nx = stlc_pkg::ST_LOW_BATT;
				end else if (wd_cnt_nx > wd_limit_q) begin
					status_nx = stlc_pkg::ST_WATCHDOG;
					seen_nx   = 1'b0;
					act_nx[0] = stlc_pkg::LEVEL_ON;
					act_nx[1] = 8'd0;
					act_nx[2] = 8'd0;
				end else if (!seen_q) begin
					status_nx = stlc_pkg::ST_NO_CMD;
					act_nx[0] = stlc_pkg::LEVEL_ON;
					act_nx[1] = 8'd0;
					act_nx[2] = 8'd0;
				end else if (csum_q) begin
					status_nx = stlc_pkg::ST_CSUM_WARN;
					csum_nx   = 1'b0;
				end else begin
					status_nx = stlc_pkg::ST_OK;
					act_nx    = cmd_q;
				end

				// step the flashers and sample the battery on every second tick
				led_level = {5'd0, status_nx} + 8'd1;
				if (half_q) begin
					half_nx = 1'b0;
					fl_nx[stlc_pkg::CH_LED] = flash_step(fl_q[stlc_pkg::CH_LED], led_level);
					for (int i = 0; i < stlc_pkg::N_LAMPS; i++)
						fl_nx[i] = flash_step(fl_q[i], act_nx[i]);
					batt_flag_nx = sample < batt_min_q;
				end else begin
					half_nx = 1'b1;
				end
			end
			stlc_pkg::OP_CMD: begin
				wd_cnt_nx = 16'd0;
				seen_nx   = 1'b1;
				cmd_nx[0] = s_tdata[17:10];
				cmd_nx[1] = s_tdata[25:18];
				cmd_nx[2] = s_tdata[33:26];
			end
			stlc_pkg::OP_CSUM: begin
				csum_nx = 1'b1;
			end
			default: ;
		endcase

		// pack the result from the updated state
		out_data_nx = {batt_flag_nx, status_nx, fl_nx[3].drive, fl_nx[2].drive,
			fl_nx[1].drive, fl_nx[0].drive};
	end

	// Advance state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q      <= 1'b0;
			wd_cnt_q    <= stlc_pkg::WD_COUNT_RST;
			seen_q      <= 1'b0;
			csum_q      <= 1'b0;
			batt_flag_q <= 1'b0;
			status_q    <= stlc_pkg::ST_WATCHDOG;
			for (int i = 0; i < stlc_pkg::N_LAMPS; i++) begin
				cmd_q[i] <= 8'd0;
				act_q[i] <= 8'd0;
			end
			act_q[0] <= stlc_pkg::LEVEL_ON;
			for (int i = 0; i < stlc_pkg::N_CHANS; i++)
				fl_q[i] <= '0;
		end else if (s_acc) begin
			half_q      <= half_nx;
			wd_cnt_q    <= wd_cnt_nx;
			seen_q      <= seen_nx;
			csum_q      <= csum_nx;
			batt_flag_q <= batt_flag_nx;
			status_q    <= status_nx;
			cmd_q       <= cmd_nx;
			act_q       <= act_nx;
			fl_q        <= fl_nx;
		end
	end

	// Hold the result until the downstream side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_acc) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc)
			out_data_q <= out_data_nx;
	end

	// Forced statuses always leave red steady and the others off
	a_forced_red: assert property (@(posedge clk) disable iff (!arst_n)
		(status_q == stlc_pkg::ST_WATCHDOG || status_q == stlc_pkg::ST_NO_CMD) |->
		(act_q[0] == stlc_pkg::LEVEL_ON && act_q[1] == 8'd0 && act_q[2] == 8'd0))
		else $error("forced status without red steady");

	// A lamp command clears the watchdog
	a_cmd_clears_wd: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && op == stlc_pkg::OP_CMD) |=> (wd_cnt_q == 16'd0 && seen_q))
		else $error("lamp command did not clear the watchdog");

	// Back-pressure only while a result is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (out_valid_q && !m_tready))
		else $error("input stalled without a held result");

	// Reported status stays within its codes
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q[6:4] <= 3'd4))
		else $error("status code out of range");

endmodule
